// File: src/isrp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and range-code functions for the IMU sample ring packetizer.
// No dependencies; the design files take names from here by scoped reference.
package isrp_pkg;

    localparam int RING_DEPTH_DEF     = 2048;
    localparam int PACKET_SAMPLES_DEF = 16;
    localparam int COUNT_W_DEF        = $clog2(PACKET_SAMPLES_DEF + 1);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int GYRO_RANGE_W  = 12;
    localparam int ACCEL_RANGE_W = 5;
    localparam int SCALE_W       = 7;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_RANGE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_RANGE = 1'b1;

    localparam logic [GYRO_RANGE_W-1:0]  GYRO_RANGE_RST  = 12'd2000;
    localparam logic [ACCEL_RANGE_W-1:0] ACCEL_RANGE_RST = 5'd4;

    // operation codes of an input beat
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [15:0] DELTA_MAX = 16'hFFFF;

    typedef struct packed {
        logic [63:0]        time_us;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic    drain;
        t_sample sample;
    } t_cmd;

    function automatic logic [2:0] gyro_code_of(input logic [GYRO_RANGE_W-1:0] dps);
        logic [2:0] code;
        if (dps <= 12'd125) begin
            code = 3'd0;
        end else if (dps <= 12'd250) begin
            code = 3'd1;
        end else if (dps <= 12'd500) begin
            code = 3'd2;
        end else if (dps <= 12'd1000) begin
            code = 3'd3;
        end else begin
            code = 3'd4;
        end
        return code;
    endfunction

    function automatic logic [1:0] accel_code_of(input logic [ACCEL_RANGE_W-1:0] g);
        logic [1:0] code;
        if (g <= 5'd2) begin
            code = 2'd0;
        end else if (g <= 5'd4) begin
            code = 2'd1;
        end else if (g <= 5'd8) begin
            code = 2'd2;
        end else begin
            code = 2'd3;
        end
        return code;
    endfunction

    // gyro code in bits 6:4, accel code in bits 1:0, bits 3:2 zero
    function automatic logic [SCALE_W-1:0] scale_code_of(
        input logic [GYRO_RANGE_W-1:0]  dps,
        input logic [ACCEL_RANGE_W-1:0] g
    );
        return {gyro_code_of(dps), 2'b00, accel_code_of(g)};
    endfunction

endpackage

// File: src/isrp_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input beats, result beats and configuration writes.
// Depends on isrp_pkg for widths.
interface isrp_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [63:0]        time_us;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, operation, time_us, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, operation, time_us, gyro_x, gyro_y, gyro_z,
                    accel_x, accel_y, accel_z, output ready);
endinterface

interface isrp_out_if #(
    parameter int COUNT_W = isrp_pkg::COUNT_W_DEF
);
    logic                         valid;
    logic                         ready;
    logic [31:0]                  packet_sequence;
    logic [31:0]                  time_base;
    logic [isrp_pkg::SCALE_W-1:0] scale_code;
    logic [COUNT_W-1:0]           sample_count;
    logic [15:0]                  delta_us;
    logic signed [15:0]           out_gyro_x;
    logic signed [15:0]           out_gyro_y;
    logic signed [15:0]           out_gyro_z;
    logic signed [15:0]           out_accel_x;
    logic signed [15:0]           out_accel_y;
    logic signed [15:0]           out_accel_z;
    logic                         last;

    modport source (output valid, packet_sequence, time_base, scale_code, sample_count,
                    delta_us, out_gyro_x, out_gyro_y, out_gyro_z, out_accel_x,
                    out_accel_y, out_accel_z, last, input ready);
    modport sink   (input valid, packet_sequence, time_base, scale_code, sample_count,
                    delta_us, out_gyro_x, out_gyro_y, out_gyro_z, out_accel_x,
                    out_accel_y, out_accel_z, last, output ready);
endinterface

interface isrp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [isrp_pkg::CFG_INDEX_W-1:0] index;
    logic [isrp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/isrp_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies push versus drain, holds them in a 2-entry queue.
// Depends on isrp_pkg and isrp_in_if.
module isrp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    isrp_in_if.sink          i_in,
    output logic             o_cmd_valid,
    output isrp_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_pop
);

    isrp_pkg::t_cmd r_q [2];
    logic           r_wsel;
    logic           r_rsel;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    isrp_pkg::t_cmd in_cmd;
    logic           push;
    logic           pop;

    // classify the beat and pack the sample
    always_comb begin
        in_cmd.drain          = (i_in.operation == isrp_pkg::OP_DRAIN);
        in_cmd.sample.time_us = i_in.time_us;
        in_cmd.sample.gyro_x  = i_in.gyro_x;
        in_cmd.sample.gyro_y  = i_in.gyro_y;
        in_cmd.sample.gyro_z  = i_in.gyro_z;
        in_cmd.sample.accel_x = i_in.accel_x;
        in_cmd.sample.accel_y = i_in.accel_y;
        in_cmd.sample.accel_z = i_in.accel_z;
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rsel];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsel <= 1'b0;
            r_rsel <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wsel <= ~r_wsel;
            end
            if (pop) begin
                r_rsel <= ~r_rsel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wsel] <= in_cmd;
        end
    end

endmodule

// File: src/isrp_back.sv
`timescale 1ns / 1ps
// Back end: sample ring memory, pointers, packet sequencer and result register.
// Depends on isrp_pkg and isrp_out_if.
module isrp_back #(
    parameter int RING_DEPTH     = isrp_pkg::RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  isrp_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_pop,
    input  logic [isrp_pkg::SCALE_W-1:0] i_scale,
    isrp_out_if.source                   o_out
);

    localparam int PACKET_SAMPLES = isrp_pkg::PACKET_SAMPLES_DEF;
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = isrp_pkg::COUNT_W_DEF;
    localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    isrp_pkg::t_sample r_mem [RING_DEPTH];
    isrp_pkg::t_sample r_rd_data;

    logic [PTR_W-1:0]             r_wp;
    logic [PTR_W-1:0]             r_rp;
    logic [31:0]                  r_seq_ctr;
    logic [31:0]                  r_seq;
    logic [31:0]                  r_time_base;
    logic [isrp_pkg::SCALE_W-1:0] r_scale;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_left;
    logic [63:0]                  r_prev_t;
    logic [15:0]                  r_delta;
    logic                         r_first;
    logic                         r_last;
    logic                         r_out_valid;

    logic [PTR_W:0]   span;
    logic [CMP_W-1:0] avail;
    logic [CNT_W-1:0] take;
    logic [PTR_W-1:0] wp_next;
    logic [63:0]      diff;
    logic [15:0]      delta;
    logic             wr_en;
    logic             rd_en;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // occupancy of the ring, capped at one packet
    always_comb begin
        span  = {1'b0, r_wp} - {1'b0, r_rp}
              + ((r_wp < r_rp) ? (PTR_W + 1)'(RING_DEPTH) : '0);
        avail = CMP_W'(span[PTR_W-1:0]);
        take  = (avail < CMP_W'(PACKET_SAMPLES)) ? CNT_W'(avail) : CNT_W'(PACKET_SAMPLES);
    end

    assign wp_next = ptr_next(r_wp);

    // time since previous sample, zero on the first one, saturated
    assign diff  = r_rd_data.time_us - r_prev_t;
    assign delta = r_first ? 16'd0 : ((|diff[63:16]) ? isrp_pkg::DELTA_MAX : diff[15:0]);

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign wr_en     = o_cmd_pop && !i_cmd.drain;
    assign rd_en     = (r_state == S_READ)
                    || ((r_state == S_EMIT) && o_out.ready && !r_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.drain && (take != '0)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    n_state = r_last ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_seq_ctr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (wr_en) begin
                        r_wp <= wp_next;
                        // ring full: drop the oldest
                        if (wp_next == r_rp) begin
                            r_rp <= ptr_next(r_rp);
                        end
                    end else if (i_cmd_valid && (take != '0)) begin
                        r_count   <= take;
                        r_left    <= take;
                        r_seq     <= r_seq_ctr;
                        r_seq_ctr <= r_seq_ctr + 32'd1;
                        r_scale   <= i_scale;
                        r_first   <= 1'b1;
                    end
                end
                S_READ: begin
                    r_rp <= ptr_next(r_rp);
                end
                S_LOAD: begin
                    r_out_valid <= 1'b1;
                    r_delta     <= delta;
                    r_prev_t    <= r_rd_data.time_us;
                    if (r_first) begin
                        r_time_base <= r_rd_data.time_us[31:0];
                    end
                    r_first <= 1'b0;
                    r_last  <= (r_left == CNT_W'(1));
                    r_left  <= r_left - CNT_W'(1);
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (!r_last) begin
                            r_rp <= ptr_next(r_rp);
                        end
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_cmd.sample;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // read data holds until the beat is taken, so it drives the axes directly
    assign o_out.valid           = r_out_valid;
    assign o_out.packet_sequence = r_seq;
    assign o_out.time_base       = r_time_base;
    assign o_out.scale_code      = r_scale;
    assign o_out.sample_count    = r_count;
    assign o_out.delta_us        = r_delta;
    assign o_out.out_gyro_x      = r_rd_data.gyro_x;
    assign o_out.out_gyro_y      = r_rd_data.gyro_y;
    assign o_out.out_gyro_z      = r_rd_data.gyro_z;
    assign o_out.out_accel_x     = r_rd_data.accel_x;
    assign o_out.out_accel_y     = r_rd_data.accel_y;
    assign o_out.out_accel_z     = r_rd_data.accel_z;
    assign o_out.last            = r_last;

endmodule

// File: src/imu_sample_ring_packetizer.sv
`timescale 1ns / 1ps
// Top level of the IMU sample ring packetizer: configuration registers, front and back ends.
// Depends on isrp_pkg, isrp_ifs, isrp_front and isrp_back.

// Push beats store one timestamped six-axis sample in a ring of RING_DEPTH slots; at most
// RING_DEPTH-1 samples are held and a push into a full ring drops the oldest one. A drain
// beat pops up to PACKET_SAMPLES_DEF (sixteen) samples, oldest first, and sends one result
// beat per sample, each carrying the packet header (sequence, low 32 bits of the first
// timestamp, scale code, sample count), the saturated time delta to the previous sample and
// the six axes; last marks the final beat. A drain of an empty ring sends nothing and leaves
// the sequence number alone. Input beats enter a two-entry queue, so two further beats are
// taken while a result waits; after that the input stalls until the back end is idle again.
// Sequencing: a push is written to the ring while the back end is idle; a non-empty drain
// reads the first sample, then for each sample loads the result register and waits for the
// handshake, which also reads the next one; an empty drain leaves the back end idle. The
// ring memory has one write port and one registered read port feeding one result register.
// No clearing pass runs after reset: the pointers alone mark which slots hold data.
// Configuration writes are always taken and must only occur with the block idle.
module imu_sample_ring_packetizer #(
    parameter int RING_DEPTH     = isrp_pkg::RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isrp_in_if.sink     i_in,
    isrp_out_if.source  o_out,
    isrp_cfg_if.sink    i_cfg
);

    logic [isrp_pkg::GYRO_RANGE_W-1:0]  r_gyro_range;
    logic [isrp_pkg::ACCEL_RANGE_W-1:0] r_accel_range;
    logic [isrp_pkg::SCALE_W-1:0]       scale;

    logic           cmd_valid;
    isrp_pkg::t_cmd cmd;
    logic           cmd_pop;

    // configuration port: always ready, unknown indexes fall through
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_range  <= isrp_pkg::GYRO_RANGE_RST;
            r_accel_range <= isrp_pkg::ACCEL_RANGE_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                isrp_pkg::REG_GYRO_RANGE: begin
                    r_gyro_range <= i_cfg.data[isrp_pkg::GYRO_RANGE_W-1:0];
                end
                isrp_pkg::REG_ACCEL_RANGE: begin
                    r_accel_range <= i_cfg.data[isrp_pkg::ACCEL_RANGE_W-1:0];
                end
                default: begin
                    r_gyro_range <= r_gyro_range;
                end
            endcase
        end
    end

    // scale code follows the registers; the back end latches it per packet
    assign scale = isrp_pkg::scale_code_of(r_gyro_range, r_accel_range);

    isrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    isrp_back #(
        .RING_DEPTH     (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_scale     (scale),
        .o_out       (o_out)
    );

endmodule

// File: src/isrp_checker.sv
`timescale 1ns / 1ps
// Port-level assertions on the result channel of the packetizer, bound to the top level.
// Depends on imu_sample_ring_packetizer and its interface ports.
module isrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic [15:0] out_delta,
    input logic [31:0] out_seq
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_delta) && $stable(out_seq))
        else $error("result beat dropped or changed while stalled");

    // no result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // each sample needs a fresh memory read, so a taken beat leaves a gap
    a_gap_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result valid in the cycle after a taken beat");

    // sequence number stays the same between beats of one packet
    a_seq_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_last |=> out_seq == $past(out_seq))
        else $error("sequence number changed inside a packet");

endmodule

bind imu_sample_ring_packetizer isrp_checker u_isrp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_last  (o_out.last),
    .out_delta (o_out.delta_us),
    .out_seq   (o_out.packet_sequence)
);
